/* src/grm_pkg.sv */
package grm_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int STEP_LIMIT  = 4096;

  localparam int COL_W     = 6;
  localparam int ROW_W     = 6;
  localparam int START_W   = 19;
  localparam int STEP_W    = 16;
  localparam int POS_W     = 21;
  localparam int CAUSE_W   = 2;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam int CELL_SHIFT = 13;
  localparam int CELL_SIZE  = 1 << CELL_SHIFT;
  localparam int CELL_W     = POS_W - 1 - CELL_SHIFT;
  localparam int LIM_W      = 9;
  localparam int MAP_DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W     = $clog2(MAP_DEPTH);
  localparam int CNT_W      = $clog2(STEP_LIMIT + 1);

  localparam logic signed [POS_W-1:0] NEG_EDGE = -POS_W'(CELL_SIZE);
  localparam logic signed [POS_W-1:0] POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } reg_idx_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_WALL  = 2'd0,
    CAUSE_EXIT  = 2'd1,
    CAUSE_LIMIT = 2'd2
  } cause_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK,
    ST_ADD_X,
    ST_ADD_Y,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic load;
    logic add_x;
    logic add_y;
  } march_ctl_t;

  typedef struct packed {
    logic              out_of_map;
    logic              at_limit;
    logic [ADDR_W-1:0] rd_addr;
  } march_st_t;

  typedef struct packed {
    logic              valid;
    logic              opcode;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_ok;
    logic              wall;
  } seq_req_t;

  function automatic logic [ADDR_W-1:0] map_addr(input logic [CELL_W-1:0] row,
                                                 input logic [CELL_W-1:0] col);
    return ADDR_W'(int'(row) * MAX_COLUMNS + int'(col));
  endfunction

  function automatic logic [LIM_W-1:0] clamp_lim(input logic [CFG_W-1:0] cfg,
                                                 input int lim_max);
    if (int'(cfg) > lim_max) return LIM_W'(lim_max);
    return LIM_W'(cfg);
  endfunction

endpackage

/* src/grm_in_if.sv */
interface grm_in_if import grm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [COL_W-1:0]         cell_column;
  logic [ROW_W-1:0]         cell_row;
  logic                     cell_is_wall;
  logic [START_W-1:0]       start_x;
  logic [START_W-1:0]       start_y;
  logic signed [STEP_W-1:0] step_x;
  logic signed [STEP_W-1:0] step_y;

  modport source (
    output valid, opcode, cell_column, cell_row, cell_is_wall,
           start_x, start_y, step_x, step_y,
    input  ready
  );

  modport sink (
    input  valid, opcode, cell_column, cell_row, cell_is_wall,
           start_x, start_y, step_x, step_y,
    output ready
  );
endinterface

/* src/grm_out_if.sv */
interface grm_out_if import grm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] end_x;
  logic signed [POS_W-1:0] end_y;
  logic [CAUSE_W-1:0]      stop_cause;

  modport source (
    output valid, end_x, end_y, stop_cause,
    input  ready
  );

  modport sink (
    input  valid, end_x, end_y, stop_cause,
    output ready
  );
endinterface

/* src/grm_ram.sv */
module grm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* src/grm_march.sv */
module grm_march import grm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  march_ctl_t               ctl,
  input  logic [START_W-1:0]       start_x,
  input  logic [START_W-1:0]       start_y,
  input  logic signed [STEP_W-1:0] step_x,
  input  logic signed [STEP_W-1:0] step_y,
  input  logic [CFG_W-1:0]         map_columns,
  input  logic [CFG_W-1:0]         map_rows,
  output march_st_t                st,
  output logic signed [POS_W-1:0]  pos_x,
  output logic signed [POS_W-1:0]  pos_y
);

  logic signed [POS_W-1:0]  pos_x_r, pos_x_nxt;
  logic signed [POS_W-1:0]  pos_y_r, pos_y_nxt;
  logic signed [STEP_W-1:0] stp_x_r, stp_y_r;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [POS_W-1:0]  add_a;
  logic signed [STEP_W-1:0] add_b;
  logic signed [POS_W:0]    add_sum;
  logic signed [POS_W-1:0]  add_sat;
  logic [LIM_W-1:0]         cols_lim;
  logic [LIM_W-1:0]         rows_lim;

  function automatic logic cell_inside(input logic signed [POS_W-1:0] pos,
                                       input logic [LIM_W-1:0] lim);
    logic [CELL_W-1:0] c;
    c = pos[POS_W-2:CELL_SHIFT];
    if (pos[POS_W-1]) return (pos > NEG_EDGE) && (lim != '0);
    return LIM_W'(c) < lim;
  endfunction

  function automatic logic [CELL_W-1:0] cell_index(input logic signed [POS_W-1:0] pos);
    if (pos[POS_W-1]) return '0;
    return pos[POS_W-2:CELL_SHIFT];
  endfunction

  // shared saturating adder, x then y
  always_comb begin
    add_a   = ctl.add_y ? pos_y_r : pos_x_r;
    add_b   = ctl.add_y ? stp_y_r : stp_x_r;
    add_sum = {add_a[POS_W-1], add_a} + (POS_W+1)'(add_b);
    if (add_sum[POS_W] != add_sum[POS_W-1]) begin
      add_sat = add_sum[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      add_sat = add_sum[POS_W-1:0];
    end
  end

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    cnt_nxt   = cnt_r;
    if (ctl.load) begin
      pos_x_nxt = POS_W'(start_x);
      pos_y_nxt = POS_W'(start_y);
      cnt_nxt   = '0;
    end else if (ctl.add_x) begin
      pos_x_nxt = add_sat;
    end else if (ctl.add_y) begin
      pos_y_nxt = add_sat;
      cnt_nxt   = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      cnt_r   <= '0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      stp_x_r <= step_x;
      stp_y_r <= step_y;
    end
  end

  always_comb begin
    cols_lim      = clamp_lim(map_columns, MAX_COLUMNS);
    rows_lim      = clamp_lim(map_rows, MAX_ROWS);
    st.out_of_map = !(cell_inside(pos_x_r, cols_lim) && cell_inside(pos_y_r, rows_lim));
    st.at_limit   = cnt_r >= CNT_W'(STEP_LIMIT);
    st.rd_addr    = map_addr(cell_index(pos_y_r), cell_index(pos_x_r));
  end

  assign pos_x = pos_x_r;
  assign pos_y = pos_y_r;

endmodule

/* src/grm_seq.sv */
module grm_seq import grm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  seq_req_t          req,
  input  march_st_t         st,
  input  logic              ram_rdata,
  input  logic              out_free,
  output logic              in_ready,
  output march_ctl_t        ctl,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_addr,
  output logic              ram_wdata,
  output logic              res_load,
  output cause_t            res_cause
);

  seq_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  cause_t            cause_r, cause_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cause_r <= cause_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cause_nxt = cause_r;
    in_ready  = 1'b0;
    ctl       = '0;
    ram_we    = 1'b0;
    ram_addr  = st.rd_addr;
    ram_wdata = 1'b0;
    res_load  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == ADDR_W'(MAP_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (req.valid) begin
          if (req.opcode == OP_CAST) begin
            ctl.load  = 1'b1;
            state_nxt = ST_LOOKUP;
          end else begin
            ram_we    = req.wr_ok;
            ram_addr  = req.wr_addr;
            ram_wdata = req.wall;
          end
        end
      end
      ST_LOOKUP: begin
        if (st.out_of_map) begin
          cause_nxt = CAUSE_EXIT;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (ram_rdata) begin
          cause_nxt = CAUSE_WALL;
          state_nxt = ST_DONE;
        end else if (st.at_limit) begin
          cause_nxt = CAUSE_LIMIT;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_ADD_X;
        end
      end
      ST_ADD_X: begin
        ctl.add_x = 1'b1;
        state_nxt = ST_ADD_Y;
      end
      ST_ADD_Y: begin
        ctl.add_y = 1'b1;
        state_nxt = ST_LOOKUP;
      end
      ST_DONE: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res_cause = cause_r;

endmodule

/* src/grid_ray_march.sv */
// Ray march over a one-bit wall map of grid cells.
// in_ch carries one word per item: opcode OP_WRITE sets or clears one map
// cell and gives no result; opcode OP_CAST loads a start position and a step
// vector (13 fraction bits) and marches until the cell under the position is
// outside the used columns and rows, holds a wall, or the step limit is hit.
// out_ch carries one word per cast: end position and stop cause.
// cfg_we/cfg_index/cfg_wdata write the column and row counts; write them
// only while no cast is in flight.
// A write leaves in_ch.ready high. A cast keeps in_ch.ready low until its
// result word is loaded (one lookup, one map read, an x add and a y add per
// step through the one shared adder, ending at a lookup when it leaves the
// map); the result word is valid in the cycle that in_ch.ready rises again.
// Up to STEP_LIMIT steps per cast.
// Reset: the map is cleared by a pass over all MAP_DEPTH entries, one entry
// per cycle, during which in_ch.ready stays low.
// A stalled result word holds in the output register; the block still takes
// writes and the next cast, and a finished cast waits until the word is taken.
module grid_ray_march import grm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  grm_in_if.sink               in_ch,
  grm_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0]        cols_r;
  logic [CFG_W-1:0]        rows_r;
  seq_req_t                req;
  march_st_t               st;
  march_ctl_t              ctl;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_addr;
  logic                    ram_wdata;
  logic                    ram_rdata;
  logic                    res_load;
  cause_t                  res_cause;
  logic                    out_free;
  logic                    in_ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                    out_valid_r;
  logic signed [POS_W-1:0] end_x_r;
  logic signed [POS_W-1:0] end_y_r;
  logic [CAUSE_W-1:0]      cause_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= CFG_W'(64);
      rows_r <= CFG_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS: cols_r <= cfg_wdata;
        REG_ROWS:    rows_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    req.valid   = in_ch.valid;
    req.opcode  = in_ch.opcode;
    req.wr_addr = map_addr(CELL_W'(in_ch.cell_row), CELL_W'(in_ch.cell_column));
    req.wr_ok   = (int'(in_ch.cell_column) < MAX_COLUMNS) &&
                  (int'(in_ch.cell_row) < MAX_ROWS);
    req.wall    = in_ch.cell_is_wall;
  end

  grm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .st        (st),
    .ram_rdata (ram_rdata),
    .out_free  (out_free),
    .in_ready  (in_ready),
    .ctl       (ctl),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .res_load  (res_load),
    .res_cause (res_cause)
  );

  grm_march u_march (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .start_x     (in_ch.start_x),
    .start_y     (in_ch.start_y),
    .step_x      (in_ch.step_x),
    .step_y      (in_ch.step_y),
    .map_columns (cols_r),
    .map_rows    (rows_r),
    .st          (st),
    .pos_x       (pos_x),
    .pos_y       (pos_y)
  );

  grm_ram #(
    .WIDTH (1),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      end_x_r <= pos_x;
      end_y_r <= pos_y;
      cause_r <= res_cause;
    end
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.end_x      = end_x_r;
  assign out_ch.end_y      = end_y_r;
  assign out_ch.stop_cause = cause_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result word overwritten");

  a_idle_no_add: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!ctl.add_x && !ctl.add_y))
    else $error("adder active while taking input");

  a_limit_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && res_cause == CAUSE_LIMIT) |-> st.at_limit)
    else $error("step limit cause without limit reached");

  a_exit_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && res_cause == CAUSE_EXIT) |-> st.out_of_map)
    else $error("exit cause while inside the map");

endmodule
